>>> hw/rtl/sxr_pkg.sv
// sxr_pkg: shared constants, types and the mixing index table for the
// position-keyed salsa20 xor block. No dependencies.
package sxr_pkg;

  localparam int DATA_W        = 8;
  localparam int POS_W         = 38;
  localparam int OFF_W         = 6;
  localparam int INDEX_W       = POS_W - OFF_W;
  localparam int WORD_W        = 32;
  localparam int BLOCK_WORDS   = 16;
  localparam int KEY_WORDS     = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int DR_W          = $clog2(DOUBLE_ROUNDS);

  localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3332_2d6b;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h6e64_7974;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h616c_6267;

  typedef logic [WORD_W-1:0] word_t;

  // half 0 is the column round, half 1 the row round; roles are p, q, r, t
  localparam logic [3:0] MIX_IDX [2][4][4] = '{
    '{'{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2,  4'd6},
      '{4'd15, 4'd3,  4'd7,  4'd11}},
    '{'{4'd0,  4'd1,  4'd2,  4'd3},
      '{4'd5,  4'd6,  4'd7,  4'd4},
      '{4'd10, 4'd11, 4'd8,  4'd9},
      '{4'd15, 4'd12, 4'd13, 4'd14}}
  };

  typedef struct packed {
    logic       emit_hit;
    logic       start_block;
    logic       round;
    logic       final_add;
    logic       emit_miss;
    logic [1:0] step;
    logic       half;
  } sxr_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } sxr_status_t;

  // rotate amount follows the mixing step: 7, 9, 13, 18
  function automatic word_t rotl_step(word_t v, logic [1:0] step);
    word_t r;
    unique case (step)
      2'd0: r = {v[WORD_W-8:0],  v[WORD_W-1:WORD_W-7]};
      2'd1: r = {v[WORD_W-10:0], v[WORD_W-1:WORD_W-9]};
      2'd2: r = {v[WORD_W-14:0], v[WORD_W-1:WORD_W-13]};
      2'd3: r = {v[WORD_W-19:0], v[WORD_W-1:WORD_W-18]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/sxr_if.sv
// sxr_item_if and sxr_result_if: valid/ready channels for input items and
// result items. Depends on sxr_pkg.
interface sxr_item_if import sxr_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic [POS_W-1:0]  position;

  modport source (output valid, data_byte, position, input ready);
  modport sink   (input valid, data_byte, position, output ready);
endinterface

interface sxr_result_if import sxr_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

>>> hw/rtl/sxr_ctrl.sv
// sxr_ctrl: sequencer for accept, block generation and result hand-off.
// Depends on sxr_pkg.
module sxr_ctrl import sxr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  sxr_status_t status,
  output sxr_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_FINAL = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [1:0]      step;
  logic            half;
  logic [DR_W-1:0] dround;
  logic            accept;
  logic            last_round;

  assign item_ready = (state == S_IDLE) && status.out_free;
  assign accept     = item_valid && item_ready;
  assign last_round = (step == 2'd3) && half && (dround == DR_W'(DOUBLE_ROUNDS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && !status.hit) state_next = S_ROUND;
      S_ROUND: if (last_round) state_next = S_FINAL;
      S_FINAL: state_next = S_EMIT;
      S_EMIT:  if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= 2'd0;
      half   <= 1'b0;
      dround <= '0;
    end else begin
      state <= state_next;
      if (state == S_ROUND) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          half <= ~half;
          if (half) dround <= dround + DR_W'(1);
        end
      end else begin
        step   <= 2'd0;
        half   <= 1'b0;
        dround <= '0;
      end
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.emit_hit    = accept && status.hit;
    cmd.start_block = accept && !status.hit;
    cmd.round       = (state == S_ROUND);
    cmd.final_add   = (state == S_FINAL);
    cmd.emit_miss   = (state == S_EMIT) && status.out_free;
    cmd.step        = step;
    cmd.half        = half;
  end

endmodule

>>> hw/rtl/sxr_datapath.sv
// sxr_datapath: key registers, block cache, round unit and result register.
// Depends on sxr_pkg.
module sxr_datapath import sxr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic [DATA_W-1:0]    in_data,
  input  logic [POS_W-1:0]     in_pos,
  input  sxr_cmd_t             cmd,
  output sxr_status_t          status,
  input  logic                 res_ready,
  output logic                 res_valid,
  output logic [DATA_W-1:0]    res_byte
);

  word_t               key [KEY_WORDS];
  word_t               w [BLOCK_WORDS];
  word_t               w_next [BLOCK_WORDS];
  word_t               start [BLOCK_WORDS];
  word_t               ks [BLOCK_WORDS];
  logic [INDEX_W-1:0]  cached_index;
  logic                cache_valid;
  logic [DATA_W-1:0]   item_data;
  logic [OFF_W-1:0]    item_off;
  logic [INDEX_W-1:0]  in_index;
  logic [OFF_W-1:0]    rd_off;
  word_t               rd_word;
  logic [DATA_W-1:0]   ks_byte;
  logic [DATA_W-1:0]   src_data;
  logic                key_wr;

  assign in_index        = in_pos[POS_W-1:OFF_W];
  assign status.hit      = cache_valid && (in_index == cached_index);
  assign status.out_free = !res_valid || res_ready;
  assign key_wr          = cfg_we && (cfg_index < CFG_IDX_W'(KEY_WORDS));

  always_comb begin
    start[0]  = SIGMA0;
    start[1]  = key[0];
    start[2]  = key[1];
    start[3]  = key[2];
    start[4]  = key[3];
    start[5]  = SIGMA1;
    // index word comes from the input while a block starts
    start[6]  = word_t'(cmd.start_block ? in_index : cached_index);
    start[7]  = '0;
    start[8]  = '0;
    start[9]  = '0;
    start[10] = SIGMA2;
    start[11] = key[4];
    start[12] = key[5];
    start[13] = key[6];
    start[14] = key[7];
    start[15] = SIGMA3;
  end

  // one mixing step of all four quarter rounds of the current half round
  always_comb begin
    logic [1:0] ra, rb, rd;
    logic [3:0] ia, ib, id;
    word_t      sum;
    w_next = w;
    ra = cmd.step;
    rb = cmd.step - 2'd1;
    rd = cmd.step + 2'd1;
    for (int g = 0; g < 4; g++) begin
      ia  = MIX_IDX[cmd.half][g][ra];
      ib  = MIX_IDX[cmd.half][g][rb];
      id  = MIX_IDX[cmd.half][g][rd];
      sum = w[ia] + w[ib];
      w_next[id] = w[id] ^ rotl_step(sum, cmd.step);
    end
  end

  // miss items read the cache from the latched offset, hits from the input
  assign rd_off   = cmd.emit_miss ? item_off : in_pos[OFF_W-1:0];
  assign rd_word  = ks[rd_off[OFF_W-1:2]];
  assign ks_byte  = rd_word[{rd_off[1:0], 3'b000} +: DATA_W];
  assign src_data = cmd.emit_miss ? item_data : in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) key[i] <= '0;
      cached_index <= '0;
      cache_valid  <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (key_wr) key[cfg_index[$clog2(KEY_WORDS)-1:0]] <= cfg_data;
      if (cmd.start_block) cached_index <= in_index;
      if (key_wr || cmd.start_block) cache_valid <= 1'b0;
      else if (cmd.final_add) cache_valid <= 1'b1;
      if (cmd.emit_hit || cmd.emit_miss) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      item_data <= in_data;
      item_off  <= in_pos[OFF_W-1:0];
      w         <= start;
    end else if (cmd.round) begin
      w <= w_next;
    end
    if (cmd.final_add) begin
      for (int i = 0; i < BLOCK_WORDS; i++) ks[i] <= w[i] + start[i];
    end
    if (cmd.emit_hit || cmd.emit_miss) res_byte <= src_data ^ ks_byte;
  end

endmodule

>>> hw/rtl/salsa20_position_keyed_xor_top.sv
// salsa20_position_keyed_xor_top: byte xor with a position-keyed salsa20
// keystream. Depends on sxr_pkg, sxr_if, sxr_ctrl and sxr_datapath.
//
//   channel       dir  payload                   handshake
//   item_chan     in   data_byte[7:0], position  valid/ready
//   result_chan   out  out_byte[7:0]             valid/ready
//   cfg           in   cfg_index[3:0], cfg_data  cfg_we, no wait
//
// an item in the cached block is served from the cached keystream; an item in
// a new block first waits for the round unit to build that block over
// DOUBLE_ROUNDS double rounds, one mixing step of four quarter rounds per cycle.
// rst clears the keys, the cache flag and the result register; no clearing pass.
// a stalled result holds off new items; key writes drop the cached block.
module salsa20_position_keyed_xor_top import sxr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  sxr_item_if.sink             item_chan,
  sxr_result_if.source         result_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  sxr_cmd_t    cmd;
  sxr_status_t status;

  sxr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_chan.valid),
    .item_ready (item_chan.ready),
    .status     (status),
    .cmd        (cmd)
  );

  sxr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (item_chan.data_byte),
    .in_pos    (item_chan.position),
    .cmd       (cmd),
    .status    (status),
    .res_ready (result_chan.ready),
    .res_valid (result_chan.valid),
    .res_byte  (result_chan.out_byte)
  );

endmodule

>>> hw/rtl/sxr_checker.sv
// sxr_checker: port-level checks for the salsa20 xor top, bound to it below.
// Depends on sxr_pkg and salsa20_position_keyed_xor_top.
module sxr_checker import sxr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [DATA_W-1:0] res_byte
);

  // a stalled result blocks new items
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |-> (!res_valid || res_ready))
    else $error("item accepted while a result is stalled");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> $stable(res_byte))
    else $error("result changed while stalled");

endmodule

bind salsa20_position_keyed_xor_top sxr_checker u_sxr_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_chan.valid),
  .item_ready (item_chan.ready),
  .res_valid  (result_chan.valid),
  .res_ready  (result_chan.ready),
  .res_byte   (result_chan.out_byte)
);

>>> bench/tb_salsa20_position_keyed_xor_top.sv
`timescale 1ns / 1ps
// tb_salsa20_position_keyed_xor_top: directed table and random byte streams through the
// salsa20 position-keyed xor, checked against a salsa20 keystream predictor.
// Depends on sxr_pkg, sxr_if and salsa20_position_keyed_xor_top.
module tb_salsa20_position_keyed_xor_top;
  import sxr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MISS_CYCLES     = 3 + 8 * DOUBLE_ROUNDS;
  localparam int ITEMS_PER_PHASE = 400;

  localparam word_t SALSA_C0 = 32'h6170_7865;
  localparam word_t SALSA_C1 = 32'h3332_2d6b;
  localparam word_t SALSA_C2 = 32'h6e64_7974;
  localparam word_t SALSA_C3 = 32'h616c_6267;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 4'd0, REG_KEY1 = 4'd1, REG_KEY2 = 4'd2, REG_KEY3 = 4'd3,
    REG_KEY4 = 4'd4, REG_KEY5 = 4'd5, REG_KEY6 = 4'd6, REG_KEY7 = 4'd7,
    REG_SPARE_LO = 4'd8, REG_SPARE_HI = 4'd15
  } key_reg_e;

  typedef enum {ROW_ITEM, ROW_KEY} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  pos;
    key_reg_e          reg_sel;
    word_t             value;
  } stim_row_t;

  stim_row_t directed_rows [24] = '{
    '{ROW_ITEM, 8'h00, 38'h0,           REG_KEY0, 32'h0},
    '{ROW_ITEM, 8'hFF, 38'h1,           REG_KEY0, 32'h0},
    '{ROW_ITEM, 8'hA5, 38'd63,          REG_KEY0, 32'h0},
    '{ROW_ITEM, 8'h5A, 38'd64,          REG_KEY0, 32'h0},
    '{ROW_ITEM, 8'h00, 38'h3F_FFFF_FFFF, REG_KEY0, 32'h0},
    '{ROW_ITEM, 8'hFF, 38'h3F_FFFF_FFC0, REG_KEY0, 32'h0},
    '{ROW_ITEM, 8'h3C, 38'h0,           REG_KEY0, 32'h0},
    // same block index after a key write must be rebuilt
    '{ROW_KEY,  8'h00, 38'h0,           REG_KEY0, 32'hFFFF_FFFF},
    '{ROW_ITEM, 8'h00, 38'h0,           REG_KEY0, 32'h0},
    '{ROW_KEY,  8'h00, 38'h0,           REG_KEY1, 32'hFFFF_FFFF},
    '{ROW_KEY,  8'h00, 38'h0,           REG_KEY2, 32'hFFFF_FFFF},
    '{ROW_KEY,  8'h00, 38'h0,           REG_KEY3, 32'hFFFF_FFFF},
    '{ROW_KEY,  8'h00, 38'h0,           REG_KEY4, 32'hFFFF_FFFF},
    '{ROW_KEY,  8'h00, 38'h0,           REG_KEY5, 32'hFFFF_FFFF},
    '{ROW_KEY,  8'h00, 38'h0,           REG_KEY6, 32'hFFFF_FFFF},
    '{ROW_KEY,  8'h00, 38'h0,           REG_KEY7, 32'hFFFF_FFFF},
    '{ROW_ITEM, 8'h96, 38'd5,           REG_KEY0, 32'h0},
    // writes past the key list change nothing, cached block stays
    '{ROW_KEY,  8'h00, 38'h0,           REG_SPARE_LO, 32'h1234_5678},
    '{ROW_ITEM, 8'h81, 38'd6,           REG_KEY0, 32'h0},
    '{ROW_KEY,  8'h00, 38'h0,           REG_SPARE_HI, 32'hFFFF_FFFF},
    '{ROW_ITEM, 8'h7E, 38'h20_0000_0000, REG_KEY0, 32'h0},
    '{ROW_ITEM, 8'hC3, 38'h1F_FFFF_FFFF, REG_KEY0, 32'h0},
    '{ROW_ITEM, 8'h01, 38'h15_5555_5555, REG_KEY0, 32'h0},
    '{ROW_ITEM, 8'h80, 38'h2A_AAAA_AAAA, REG_KEY0, 32'h0}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_data;

  sxr_item_if   item_chan ();
  sxr_result_if result_chan ();

  salsa20_position_keyed_xor_top dut (
    .clk         (clk),
    .rst         (rst),
    .item_chan   (item_chan),
    .result_chan (result_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // predictor state
  word_t             key_w [KEY_WORDS];
  word_t             ks_block [BLOCK_WORDS];
  word_t             mix_w [BLOCK_WORDS];
  logic [31:0]       cached_idx;
  bit                cache_ok;
  logic [DATA_W-1:0] pending_out_bytes [$];

  int mismatch_count;
  int idle_cycles;
  int send_idle_pct;
  int stall_pct;

  function automatic word_t rotl(word_t v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void mix4(int p, int q, int r, int t);
    mix_w[q] ^= rotl(mix_w[p] + mix_w[t], 7);
    mix_w[r] ^= rotl(mix_w[q] + mix_w[p], 9);
    mix_w[t] ^= rotl(mix_w[r] + mix_w[q], 13);
    mix_w[p] ^= rotl(mix_w[t] + mix_w[r], 18);
  endfunction

  function automatic void build_keystream(logic [31:0] blk_idx);
    word_t init_w [BLOCK_WORDS];
    init_w[0]  = SALSA_C0;
    init_w[1]  = key_w[0];
    init_w[2]  = key_w[1];
    init_w[3]  = key_w[2];
    init_w[4]  = key_w[3];
    init_w[5]  = SALSA_C1;
    init_w[6]  = blk_idx;
    init_w[7]  = '0;
    init_w[8]  = '0;
    init_w[9]  = '0;
    init_w[10] = SALSA_C2;
    init_w[11] = key_w[4];
    init_w[12] = key_w[5];
    init_w[13] = key_w[6];
    init_w[14] = key_w[7];
    init_w[15] = SALSA_C3;
    for (int i = 0; i < BLOCK_WORDS; i++) mix_w[i] = init_w[i];
    for (int n = 0; n < DOUBLE_ROUNDS; n++) begin
      // columns, then rows
      mix4(0, 4, 8, 12);
      mix4(5, 9, 13, 1);
      mix4(10, 14, 2, 6);
      mix4(15, 3, 7, 11);
      mix4(0, 1, 2, 3);
      mix4(5, 6, 7, 4);
      mix4(10, 11, 8, 9);
      mix4(15, 12, 13, 14);
    end
    for (int i = 0; i < BLOCK_WORDS; i++) ks_block[i] = mix_w[i] + init_w[i];
  endfunction

  function automatic logic [DATA_W-1:0] salsa_xor_byte(logic [DATA_W-1:0] d,
                                                      logic [POS_W-1:0] pos);
    logic [31:0] blk_idx;
    logic [5:0]  off;
    word_t       w;
    blk_idx = pos[POS_W-1:6];
    off     = pos[5:0];
    if (!cache_ok || blk_idx != cached_idx) begin
      build_keystream(blk_idx);
      cached_idx = blk_idx;
      cache_ok   = 1'b1;
    end
    w = ks_block[off[5:2]];
    return d ^ w[off[1:0]*8 +: 8];
  endfunction

  function automatic void load_key(logic [CFG_IDX_W-1:0] idx, word_t v);
    if (idx < KEY_WORDS) begin
      key_w[idx[2:0]] = v;
      cache_ok = 1'b0;
    end
  endfunction

  // append one expected byte at the tail of the queue
  function automatic void queue_expected(logic [DATA_W-1:0] b);
    pending_out_bytes.insert(pending_out_bytes.size(), b);
  endfunction

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // receiver back-pressure
  initial result_chan.ready = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      result_chan.ready <= 1'b0;
    end else begin
      result_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // prediction and checking
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) key_w[i] = '0;
      for (int i = 0; i < BLOCK_WORDS; i++) ks_block[i] = '0;
      cached_idx = '0;
      cache_ok   = 1'b0;
      pending_out_bytes.delete();
    end else begin
      if (cfg_we) load_key(cfg_index, cfg_data);
      if (result_chan.valid && result_chan.ready) begin
        if (pending_out_bytes.size() == 0) begin
          $error("out_byte: expected none, got %02h", result_chan.out_byte);
          mismatch_count++;
        end else begin
          logic [DATA_W-1:0] want;
          want = pending_out_bytes.pop_front();
          if (result_chan.out_byte !== want) begin
            $error("out_byte: expected %02h, got %02h", want, result_chan.out_byte);
            mismatch_count++;
          end
        end
      end
      if (item_chan.valid && item_chan.ready)
        queue_expected(salsa_xor_byte(item_chan.data_byte, item_chan.position));
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (item_chan.valid && item_chan.ready) ||
        (result_chan.valid && result_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(logic [DATA_W-1:0] d, logic [POS_W-1:0] pos);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_chan.valid <= 1'b0;
      @(posedge clk);
    end
    item_chan.valid     <= 1'b1;
    item_chan.data_byte <= d;
    item_chan.position  <= pos;
    do @(posedge clk); while (!item_chan.ready);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    item_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_out_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, word_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    logic [POS_W-1:0] p;
    p[POS_W-1:32] = (POS_W-32)'($urandom_range(2**(POS_W-32) - 1));
    p[31:0]       = $urandom;
    return p;
  endfunction

  initial begin
    logic [31:0]      hot_idx [4];
    logic [POS_W-1:0] run_start;
    int               run_len;
    int               pick;
    int               sent;
    word_t            kv;

    mismatch_count      = 0;
    idle_cycles         = 0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    item_chan.valid     = 1'b0;
    item_chan.data_byte = '0;
    item_chan.position  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_KEY) begin
        write_cfg(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].data, directed_rows[i].pos);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      for (int k = 0; k < KEY_WORDS; k++) begin
        case (ph)
          1: kv = '0;
          2: kv = '1;
          default: kv = $urandom;
        endcase
        write_cfg(CFG_IDX_W'(REG_KEY0 + k), kv);
      end
      hot_idx[0] = '0;
      hot_idx[1] = '1;
      hot_idx[2] = $urandom;
      hot_idx[3] = $urandom;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          // contiguous stream, often crossing a block boundary
          run_start = rand_pos();
          run_len   = $urandom_range(80, 1);
          for (int j = 0; j < run_len; j++)
            send_item(DATA_W'($urandom_range(255)), run_start + POS_W'(j));
          sent += run_len;
        end else if (pick < 80) begin
          send_item(DATA_W'($urandom_range(255)),
                    {hot_idx[2'($urandom_range(3))], 6'($urandom_range(63))});
          sent++;
        end else if (pick < 95) begin
          send_item(DATA_W'($urandom_range(255)), rand_pos());
          sent++;
        end else begin
          write_cfg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_KEY0)), $urandom);
        end
      end
    end

    item_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_out_bytes.size() != 0) @(posedge clk);
    repeat (MISS_CYCLES + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
